[rtl/csu_pkg.sv]
// ----------------------------------------------------------------------------
// csu_pkg
// Shared widths, tag types and sequencing constants of the cosine similarity
// unit.
// ----------------------------------------------------------------------------
package csu_pkg;

	localparam int MAX_ELEMENTS = 4096;

	localparam int ELEM_W = 16;
	localparam int FRAC_W = 15;
	localparam int LIMB_W = 16;
	localparam int MUL_W  = ELEM_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	// accumulator widths grow with the vector length
	localparam int DOT_W = 2 * ELEM_W + $clog2(MAX_ELEMENTS);
	localparam int MAG_W = DOT_W - 1;

	// long multiply operands, split into limbs
	localparam int OPA_LIMBS = 8;
	localparam int OPB_LIMBS = 4;
	localparam int OPA_W     = OPA_LIMBS * LIMB_W;
	localparam int OPB_W     = OPB_LIMBS * LIMB_W;
	localparam int IA_W      = $clog2(OPA_LIMBS);
	localparam int JB_W      = $clog2(OPB_LIMBS);
	localparam int ACC_W     = 2 * DOT_W + 2 * FRAC_W + 2;

	localparam logic [IA_W-1:0] NA_SQ  = IA_W'((DOT_W + LIMB_W - 1) / LIMB_W - 1);
	localparam logic [IA_W-1:0] NA_PRD = IA_W'((2 * MAG_W + LIMB_W - 1) / LIMB_W - 1);
	localparam logic [JB_W-1:0] NB_LAST = JB_W'((DOT_W + LIMB_W - 1) / LIMB_W - 1);

	localparam int BIT_W = $clog2(FRAC_W + 1);
	localparam logic [ELEM_W-1:0] Q_MAX   = ELEM_W'(1) << FRAC_W;
	localparam logic [ELEM_W-1:0] SIM_MAX = Q_MAX - ELEM_W'(1);

	// where a registered product goes on the cycle after it is formed
	typedef enum logic [2:0] {
		DST_NONE,
		DST_DOT,
		DST_MAGA,
		DST_MAGB,
		DST_ACC,
		DST_OPB
	} dst_t;

	typedef struct packed {
		dst_t            dst;
		logic [IA_W-1:0] limb_sh;
	} mul_tag_t;

endpackage

[rtl/csu_if.sv]
// ----------------------------------------------------------------------------
// csu_if
// Valid/ready channels of the cosine similarity unit: element pairs in,
// similarity results out.
// ----------------------------------------------------------------------------
interface csu_in_if;
	import csu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] elem_a;
	logic signed [ELEM_W-1:0] elem_b;
	logic                     last_elem;

	modport source (output valid, output elem_a, output elem_b, output last_elem,
		input ready);
	modport sink (input valid, input elem_a, input elem_b, input last_elem,
		output ready);
endinterface

interface csu_out_if;
	import csu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] similarity;
	logic                     zero_vector;

	modport source (output valid, output similarity, output zero_vector, input ready);
	modport sink (input valid, input similarity, input zero_vector, output ready);
endinterface

[rtl/csu_mul.sv]
// ----------------------------------------------------------------------------
// csu_mul
// Shared 17x17 signed multiplier with a registered product and a tag that
// tells the sequencer where the product is to be added.
// ----------------------------------------------------------------------------
module csu_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [csu_pkg::MUL_W-1:0]    x,
	input  logic signed [csu_pkg::MUL_W-1:0]    y,
	input  csu_pkg::mul_tag_t                   tag,
	output logic signed [csu_pkg::PROD_W-1:0]   prod_s1,
	output csu_pkg::mul_tag_t                   tag_s1
);
	import csu_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '{dst: DST_NONE, limb_sh: '0};
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= x * y;
	end

endmodule

[rtl/cosine_similarity_unit.sv]
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// Cosine similarity of two signed 16-bit vectors in signed Q1.15.
// ----------------------------------------------------------------------------
// Element pairs arrive on elems; the pair with last_elem set closes a vector
// and produces one result on result, after which the sums start again from
// zero. All multiplies run through one registered 17x17 multiplier: a
// non-last pair passes the accepting state, three products and the final
// add; the last pair then forms the quotient: two 9-product long
// multiplies form |dot|^2 and mag_a*mag_b, then a 16-step bit search on
// the result runs one 18-product long multiply per step whose candidate is
// at most 1.0. The block takes no new pair until that is done, but a finished
// result may wait in the output register while the next vector streams in.
// A zero magnitude gives 0 with zero_vector set; +1.0 saturates to 32767.
module cosine_similarity_unit (
	input  logic       clk,
	input  logic       arst_n,
	csu_in_if.sink     elems,
	csu_out_if.source  result
);
	import csu_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_EAB   = 14'b00000000000010,
		ST_EAA   = 14'b00000000000100,
		ST_EBB   = 14'b00000000001000,
		ST_EACC  = 14'b00000000010000,
		ST_CHK   = 14'b00000000100000,
		ST_MUL   = 14'b00000001000000,
		ST_DRAIN = 14'b00000010000000,
		ST_LHS   = 14'b00000100000000,
		ST_PRD   = 14'b00001000000000,
		ST_BIT   = 14'b00010000000000,
		ST_TSQ   = 14'b00100000000000,
		ST_CMP   = 14'b01000000000000,
		ST_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t ret_q;

	logic [IA_W-1:0] ia_q;
	logic [JB_W-1:0] jb_q;
	logic [IA_W-1:0] na_q;

	logic signed [DOT_W-1:0] dot_q;
	logic [MAG_W-1:0]        mag_a_q;
	logic [MAG_W-1:0]        mag_b_q;

	logic signed [ELEM_W-1:0] a_q;
	logic signed [ELEM_W-1:0] b_q;
	logic                     last_q;

	logic [OPA_LIMBS-1:0][LIMB_W-1:0] op_a_q;
	logic [OPB_LIMBS-1:0][LIMB_W-1:0] op_b_q;
	logic [ACC_W-1:0]                 acc_q;
	logic [ACC_W-1:0]                 lhs_q;
	logic [ELEM_W-1:0]                q_q;
	logic [ELEM_W-1:0]                t_q;
	logic [BIT_W-1:0]                 bit_q;
	logic                             neg_q;
	logic                             zero_q;

	logic                     out_valid_q;
	logic signed [ELEM_W-1:0] sim_q;
	logic                     zf_q;

	logic signed [MUL_W-1:0]  mul_x;
	logic signed [MUL_W-1:0]  mul_y;
	mul_tag_t                 mul_tag;
	logic signed [PROD_W-1:0] prod_s1;
	mul_tag_t                 tag_s1;

	logic [ELEM_W-1:0] t_cand;
	logic              t_skip;
	logic [DOT_W-1:0]  abs_dot;
	logic              mag_zero;
	logic              out_free;
	logic [ELEM_W-1:0] sim_next;

	assign t_cand   = q_q | (ELEM_W'(1) << bit_q);
	assign t_skip   = t_cand > Q_MAX;
	assign abs_dot  = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
	assign mag_zero = (mag_a_q == '0) || (mag_b_q == '0);
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		if (zero_q) begin
			sim_next = '0;
		end else if (neg_q) begin
			sim_next = ~q_q + ELEM_W'(1);
		end else begin
			sim_next = (q_q > SIM_MAX) ? SIM_MAX : q_q;
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_x   = '0;
		mul_y   = '0;
		mul_tag = '{dst: DST_NONE, limb_sh: '0};
		case (state_q)
			ST_EAB: begin
				mul_x   = MUL_W'(a_q);
				mul_y   = MUL_W'(b_q);
				mul_tag = '{dst: DST_DOT, limb_sh: '0};
			end
			ST_EAA: begin
				mul_x   = MUL_W'(a_q);
				mul_y   = MUL_W'(a_q);
				mul_tag = '{dst: DST_MAGA, limb_sh: '0};
			end
			ST_EBB: begin
				mul_x   = MUL_W'(b_q);
				mul_y   = MUL_W'(b_q);
				mul_tag = '{dst: DST_MAGB, limb_sh: '0};
			end
			ST_MUL: begin
				mul_x   = {1'b0, op_a_q[ia_q]};
				mul_y   = {1'b0, op_b_q[jb_q]};
				mul_tag = '{dst: DST_ACC, limb_sh: ia_q + IA_W'(jb_q)};
			end
			ST_BIT: begin
				if (!t_skip) begin
					mul_x   = {1'b0, t_cand};
					mul_y   = {1'b0, t_cand};
					mul_tag = '{dst: DST_OPB, limb_sh: '0};
				end
			end
			default: begin
			end
		endcase
	end

	csu_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.x       (mul_x),
		.y       (mul_y),
		.tag     (mul_tag),
		.prod_s1 (prod_s1),
		.tag_s1  (tag_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			ia_q        <= '0;
			jb_q        <= '0;
			out_valid_q <= 1'b0;
			dot_q       <= '0;
			mag_a_q     <= '0;
			mag_b_q     <= '0;
		end else begin
			case (tag_s1.dst)
				DST_DOT:  dot_q   <= dot_q + DOT_W'(prod_s1);
				DST_MAGA: mag_a_q <= mag_a_q + MAG_W'(prod_s1);
				DST_MAGB: mag_b_q <= mag_b_q + MAG_W'(prod_s1);
				default: begin
				end
			endcase

			// drop the result once its transaction completes
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (elems.valid) begin
						state_q <= ST_EAB;
					end
				end
				ST_EAB:  state_q <= ST_EAA;
				ST_EAA:  state_q <= ST_EBB;
				ST_EBB:  state_q <= ST_EACC;
				ST_EACC: state_q <= last_q ? ST_CHK : ST_IDLE;
				ST_CHK: begin
					if (mag_zero) begin
						state_q <= ST_DONE;
					end else begin
						ret_q   <= ST_LHS;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (jb_q == NB_LAST) begin
						jb_q <= '0;
						if (ia_q == na_q) begin
							ia_q    <= '0;
							state_q <= ST_DRAIN;
						end else begin
							ia_q <= ia_q + IA_W'(1);
						end
					end else begin
						jb_q <= jb_q + JB_W'(1);
					end
				end
				ST_DRAIN: state_q <= ret_q;
				ST_LHS: begin
					ret_q   <= ST_PRD;
					state_q <= ST_MUL;
				end
				ST_PRD: state_q <= ST_BIT;
				ST_BIT: begin
					if (t_skip) begin
						if (bit_q == '0) begin
							state_q <= ST_DONE;
						end
					end else begin
						ret_q   <= ST_CMP;
						state_q <= ST_TSQ;
					end
				end
				ST_TSQ: state_q <= ST_MUL;
				ST_CMP: state_q <= (bit_q == '0) ? ST_DONE : ST_BIT;
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						dot_q       <= '0;
						mag_a_q     <= '0;
						mag_b_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (elems.valid && elems.ready) begin
			a_q    <= elems.elem_a;
			b_q    <= elems.elem_b;
			last_q <= elems.last_elem;
		end

		if (tag_s1.dst == DST_ACC) begin
			acc_q <= acc_q + (ACC_W'(prod_s1[2*LIMB_W-1:0]) << (LIMB_W * tag_s1.limb_sh));
		end
		if (tag_s1.dst == DST_OPB) begin
			op_b_q <= OPB_W'(prod_s1[2*LIMB_W-1:0]);
		end

		case (state_q)
			ST_CHK: begin
				neg_q  <= dot_q[DOT_W-1];
				zero_q <= mag_zero;
				op_a_q <= OPA_W'(abs_dot);
				op_b_q <= OPB_W'(abs_dot);
				na_q   <= NA_SQ;
				acc_q  <= '0;
			end
			ST_LHS: begin
				// dot^2 scaled by 2^30 is the fixed side of the search
				lhs_q  <= acc_q << (2 * FRAC_W);
				op_a_q <= OPA_W'(mag_a_q);
				op_b_q <= OPB_W'(mag_b_q);
				na_q   <= NA_SQ;
				acc_q  <= '0;
			end
			ST_PRD: begin
				op_a_q <= OPA_W'(acc_q[2*MAG_W-1:0]);
				na_q   <= NA_PRD;
				q_q    <= '0;
				bit_q  <= BIT_W'(FRAC_W);
			end
			ST_BIT: begin
				t_q   <= t_cand;
				acc_q <= '0;
				if (t_skip) begin
					bit_q <= bit_q - BIT_W'(1);
				end
			end
			ST_CMP: begin
				if (acc_q <= lhs_q) begin
					q_q <= t_q;
				end
				bit_q <= bit_q - BIT_W'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					sim_q <= sim_next;
					zf_q  <= zero_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign elems.ready        = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.similarity  = sim_q;
	assign result.zero_vector = zf_q;

endmodule

[test/cosine_similarity_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_unit_tb
// Self-checking bench for the cosine similarity unit.
// ----------------------------------------------------------------------------
// Streams element pairs into the block and keeps its own running dot product
// and squared magnitudes at the block's widths. On each last pair it derives
// the exact truncated Q1.15 quotient by a bitwise search and queues it. Every
// result transaction is compared with the oldest queued value. Stimulus is a
// few hand-picked vectors (+1.0 saturation, exact -1.0, zero magnitudes,
// orthogonal and opposite vectors), one long vector of opposed full-scale
// pairs, and then random vectors of mostly short length with varied content.
// ----------------------------------------------------------------------------
module cosine_similarity_unit_tb;
	import csu_pkg::*;

	localparam int RANDOM_PAIRS   = 1630;
	localparam int LONG_PAIRS     = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic signed [ELEM_W-1:0] a;
		logic signed [ELEM_W-1:0] b;
		logic                     last;
	} elem_pair_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] sim;
		logic                     zero;
	} cos_result_t;

	logic clk;
	logic arst_n;

	csu_in_if  elems_if ();
	csu_out_if result_if ();

	cosine_similarity_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.elems  (elems_if),
		.result (result_if)
	);

	elem_pair_t  pairs_to_send[$];
	cos_result_t expected_sims[$];
	elem_pair_t  next_pair;

	// running sums, same widths and wrap as the block
	logic [DOT_W-1:0] dot_run;
	logic [MAG_W-1:0] mag_a_run;
	logic [MAG_W-1:0] mag_b_run;

	int n_vectors;
	int n_pairs_sent;
	int results_seen;
	int n_errors;
	int n_zero_results;
	int n_plus_one;
	int n_minus_one;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	always #1 clk = ~clk;

	// Exact quotient: largest q with q*q*mag_a*mag_b <= dot*dot*2^30.
	function automatic cos_result_t cosine_of(input logic [DOT_W-1:0] dot,
			input logic [MAG_W-1:0] ma, input logic [MAG_W-1:0] mb);
		cos_result_t      r;
		logic [DOT_W-1:0] abs_dot;
		logic             neg;
		logic [127:0]     lhs;
		logic [127:0]     prod;
		logic [127:0]     rhs;
		logic [16:0]      q;
		logic [16:0]      cand;
		r.sim  = '0;
		r.zero = 1'b0;
		if (ma == '0 || mb == '0) begin
			r.zero = 1'b1;
			return r;
		end
		neg     = dot[DOT_W-1];
		abs_dot = neg ? -dot : dot;
		lhs     = (128'(abs_dot) * 128'(abs_dot)) << 30;
		prod    = 128'(ma) * 128'(mb);
		q       = '0;
		for (int k = 15; k >= 0; k--) begin
			cand = q | (17'd1 << k);
			if (cand <= 17'd32768) begin
				rhs = 128'(cand) * 128'(cand) * prod;
				if (rhs <= lhs)
					q = cand;
			end
		end
		if (neg)
			r.sim = ELEM_W'(17'd0 - q);
		else if (q > 17'd32767)
			r.sim = 16'sd32767;
		else
			r.sim = q[ELEM_W-1:0];
		return r;
	endfunction

	task automatic fold_pair(input logic signed [ELEM_W-1:0] a,
			input logic signed [ELEM_W-1:0] b, input logic last);
		logic signed [31:0] pab;
		logic signed [31:0] paa;
		logic signed [31:0] pbb;
		cos_result_t        r;
		pab = a * b;
		paa = a * a;
		pbb = b * b;
		dot_run   = dot_run + {{(DOT_W-32){pab[31]}}, pab};
		mag_a_run = mag_a_run + {{(MAG_W-32){1'b0}}, paa};
		mag_b_run = mag_b_run + {{(MAG_W-32){1'b0}}, pbb};
		if (last) begin
			r = cosine_of(dot_run, mag_a_run, mag_b_run);
			expected_sims = {expected_sims, r};
			if (r.zero)
				n_zero_results++;
			else if (r.sim == 16'sd32767)
				n_plus_one++;
			else if (r.sim == -16'sd32768)
				n_minus_one++;
			dot_run   = '0;
			mag_a_run = '0;
			mag_b_run = '0;
		end
	endtask

	task automatic check_result(input logic signed [ELEM_W-1:0] sim, input logic zero);
		cos_result_t want;
		if (expected_sims.size() == 0) begin
			n_errors++;
			if (n_errors <= REPORT_LIMIT)
				$display("unexpected result: similarity %0d zero_vector %0b", sim, zero);
		end else begin
			want = expected_sims.pop_front();
			if (want.sim !== sim || want.zero !== zero) begin
				n_errors++;
				if (n_errors <= REPORT_LIMIT)
					$display("result %0d: expected similarity %0d zero_vector %0b, got %0d %0b",
						results_seen, want.sim, want.zero, sim, zero);
			end
		end
	endtask

	task automatic add_pair(input int a, input int b, input bit last);
		elem_pair_t p;
		p.a    = ELEM_W'(a);
		p.b    = ELEM_W'(b);
		p.last = last;
		pairs_to_send = {pairs_to_send, p};
		if (last)
			n_vectors++;
	endtask

	function automatic int extreme_elem();
		case ($urandom_range(4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	// Content styles: full range, near-parallel or near-opposite, one vector
	// all zero, small values, extremes only.
	task automatic add_random_vector(input int len);
		int style;
		int a;
		int b;
		bit flip;
		bit zero_a;
		style  = $urandom_range(4);
		flip   = 1'($urandom_range(1));
		zero_a = 1'($urandom_range(1));
		for (int i = 0; i < len; i++) begin
			a = int'($signed(16'($urandom_range(65535))));
			b = int'($signed(16'($urandom_range(65535))));
			case (style)
				1: b = (flip ? -a : a) + int'($urandom_range(6)) - 3;
				2: if (zero_a) a = 0; else b = 0;
				3: begin
					a = int'($urandom_range(6)) - 3;
					b = int'($urandom_range(6)) - 3;
				end
				4: begin
					a = extreme_elem();
					b = extreme_elem();
				end
				default: ;
			endcase
			add_pair(a, b, i == len - 1);
		end
	endtask

	task automatic build_stimulus();
		int pct;
		int len;
		int random_count;
		// saturation at +1.0, exact -1.0, zero magnitudes
		add_pair(32767, 32767, 1);
		add_pair(-32768, -32768, 1);
		add_pair(-32768, 32767, 1);
		add_pair(0, 0, 1);
		add_pair(0, -32768, 1);
		add_pair(32767, 0, 1);
		// orthogonal, opposite, zero dot with mixed signs
		add_pair(1, 0, 0);
		add_pair(0, 1, 1);
		add_pair(100, -100, 0);
		add_pair(-3, 3, 1);
		add_pair(-1, -1, 0);
		add_pair(0, 0, 0);
		add_pair(1, -1, 1);
		add_pair(3, 4, 0);
		add_pair(4, 3, 1);
		add_pair(32767, -32768, 0);
		add_pair(-32768, 32767, 0);
		add_pair(12345, -23456, 1);
		// grow large sums with opposed full-scale pairs, close with small ones
		for (int i = 0; i < LONG_PAIRS; i++) begin
			if (i < LONG_PAIRS - 3)
				add_pair(-32768, 32767, 0);
			else
				add_pair(int'($urandom_range(200)) + 1, int'($urandom_range(200)) + 1,
					i == LONG_PAIRS - 1);
		end
		random_count = 0;
		while (random_count < RANDOM_PAIRS) begin
			pct = $urandom_range(99);
			if (pct < 75)
				len = $urandom_range(6, 1);
			else if (pct < 97)
				len = $urandom_range(32, 7);
			else
				len = $urandom_range(200, 33);
			add_random_vector(len);
			random_count += len;
		end
	endtask

	// Driver: hold valid until the transaction is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elems_if.valid     <= 1'b0;
			elems_if.elem_a    <= '0;
			elems_if.elem_b    <= '0;
			elems_if.last_elem <= 1'b0;
		end else begin
			if (elems_if.valid && elems_if.ready) begin
				fold_pair(elems_if.elem_a, elems_if.elem_b, elems_if.last_elem);
				n_pairs_sent++;
			end
			if (!elems_if.valid || elems_if.ready) begin
				if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_pair = pairs_to_send.pop_front();
					elems_if.valid     <= 1'b1;
					elems_if.elem_a    <= next_pair.a;
					elems_if.elem_b    <= next_pair.b;
					elems_if.last_elem <= next_pair.last;
				end else begin
					elems_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result and advance the idling phase by results seen.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				check_result(result_if.similarity, result_if.zero_vector);
				results_seen <= results_seen + 1;
				if (3 * (results_seen + 1) >= 2 * n_vectors) begin
					send_idle_pct <= 0;
					recv_idle_pct <= 0;
				end else if (3 * (results_seen + 1) >= n_vectors) begin
					send_idle_pct <= 81;
					recv_idle_pct <= 33;
				end
			end
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((elems_if.valid && elems_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results pending",
					quiet_cycles, expected_sims.size());
				$display("[cosine_similarity_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		elems_if.valid     = 1'b0;
		elems_if.elem_a    = '0;
		elems_if.elem_b    = '0;
		elems_if.last_elem = 1'b0;
		result_if.ready    = 1'b0;
		dot_run            = '0;
		mag_a_run          = '0;
		mag_b_run          = '0;
		n_vectors          = 0;
		n_pairs_sent       = 0;
		results_seen       = 0;
		n_errors           = 0;
		n_zero_results     = 0;
		n_plus_one         = 0;
		n_minus_one        = 0;
		quiet_cycles       = 0;
		send_idle_pct      = 33;
		recv_idle_pct      = 81;
		build_stimulus();
		repeat (2) @(posedge clk);
		arst_n = 1'b1;

		while (pairs_to_send.size() != 0 || elems_if.valid)
			@(posedge clk);
		while (expected_sims.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_sims.size() != 0)
			n_errors++;
		$display("sent %0d element pairs in %0d vectors, the longest %0d pairs",
			n_pairs_sent, n_vectors, LONG_PAIRS);
		$display("checked %0d results: %0d zero-magnitude, %0d saturated at +1, %0d at -1",
			results_seen, n_zero_results, n_plus_one, n_minus_one);
		if (n_errors == 0)
			$display("[cosine_similarity_unit] OK");
		else
			$display("[cosine_similarity_unit] ERROR");
		$finish;
	end

endmodule

[cosine_similarity_unit.f]
rtl/csu_pkg.sv
rtl/csu_if.sv
rtl/csu_mul.sv
rtl/cosine_similarity_unit.sv
test/cosine_similarity_unit_tb.sv
